FILE: design/rpae_pkg.sv
package rpae_pkg;

  // Fixed widths of the datapath.
  localparam int unsigned CoefW    = 32;
  localparam int unsigned RadW     = 16;
  localparam int unsigned AngW     = 16;
  localparam int unsigned AccW     = 44;
  localparam int unsigned AfW      = 16;
  localparam int unsigned NumCoef  = 4;
  localparam int unsigned MaxTerms = 4;
  localparam int unsigned RadFrac  = 13;
  localparam int unsigned AngFrac  = 14;

  // Sine polynomial constants in Q1.14.
  localparam logic [14:0] AngOne = 15'd16384;
  localparam logic [14:0] SinA   = 15'd25736;
  localparam logic [13:0] SinB   = 14'd10512;
  localparam logic [10:0] SinC   = 11'd1160;

  // Configuration register indexes.
  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CfgCoef0 = 3'd0;
  localparam cfg_idx_t CfgCoef1 = 3'd1;
  localparam cfg_idx_t CfgCoef2 = 3'd2;
  localparam cfg_idx_t CfgCoef3 = 3'd3;
  localparam cfg_idx_t CfgTerms = 3'd4;
  localparam cfg_idx_t CfgFreq  = 3'd5;

  typedef logic signed [CoefW-1:0] coef_t;
  typedef logic signed [AccW-1:0]  acc_t;
  typedef logic signed [AfW-1:0]   af_t;

endpackage

FILE: design/radial_poly_azimuthal_eval.sv
// Throughput: one request per cycle; the whole pipeline advances together and
// holds while the output register is full and not taken.
// Reset clears the valid bits, coefficients to zero, term count to 4 and the
// azimuthal frequency to zero.
module radial_poly_azimuthal_eval (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] radius_i,
  input  logic [15:0] angle_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [31:0] value_o,
  output logic        saturated_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic            en;
  logic [6:0]      vld_q;
  rpae_pkg::coef_t coef_q [rpae_pkg::NumCoef];
  logic [2:0]      terms_q;
  logic [6:0]      freq_q;
  rpae_pkg::acc_t  acc;
  rpae_pkg::af_t   af;
  logic signed [rpae_pkg::AccW+rpae_pkg::AfW-1:0] prod_q;
  logic signed [rpae_pkg::AccW+rpae_pkg::AfW-15:0] shr;
  logic signed [31:0] value_d, value_q;
  logic            sat_d, sat_q;

  assign en          = !vld_q[6] || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rpae_pkg::NumCoef; i++) coef_q[i] <= '0;
      terms_q <= 3'd4;
      freq_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rpae_pkg::CfgCoef0: coef_q[0] <= cfg_data_i;
        rpae_pkg::CfgCoef1: coef_q[1] <= cfg_data_i;
        rpae_pkg::CfgCoef2: coef_q[2] <= cfg_data_i;
        rpae_pkg::CfgCoef3: coef_q[3] <= cfg_data_i;
        rpae_pkg::CfgTerms: terms_q   <= cfg_data_i[2:0];
        rpae_pkg::CfgFreq:  freq_q    <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[5:0], in_valid_i};
    end
  end

  rpae_radial u_radial (
    .clk_i    (clk_i),
    .en_i     (en),
    .radius_i (radius_i),
    .coef_i   (coef_q),
    .terms_i  (terms_q),
    .acc_o    (acc)
  );

  rpae_angular u_angular (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (angle_i),
    .freq_i  (freq_q),
    .af_o    (af)
  );

  // Final scaling and saturation to Q16.16.
  assign shr = prod_q[rpae_pkg::AccW+rpae_pkg::AfW-1:rpae_pkg::AngFrac];

  always_comb begin
    value_d = 32'(shr);
    sat_d   = 1'b0;
    if (shr > $signed(46'sh0000_7FFF_FFFF)) begin
      value_d = 32'sh7FFF_FFFF;
      sat_d   = 1'b1;
    end else if (shr < -$signed(46'sh0000_8000_0000)) begin
      value_d = 32'sh8000_0000;
      sat_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q  <= acc * af;
      value_q <= value_d;
      sat_q   <= sat_d;
    end
  end

  assign out_valid_o = vld_q[6];
  assign value_o     = value_q;
  assign saturated_o = sat_q;

endmodule

FILE: design/rpae_radial.sv
module rpae_radial (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [15:0]           radius_i,
  input  rpae_pkg::coef_t       coef_i [rpae_pkg::NumCoef],
  input  logic [2:0]            terms_i,
  output rpae_pkg::acc_t        acc_o
);

  rpae_pkg::coef_t ceff [rpae_pkg::NumCoef];
  logic [2:0]      n_eff;
  rpae_pkg::acc_t  acc1_d, acc2_d, acc3_d;
  rpae_pkg::acc_t  acc1_q, acc2_q, acc3_q, acc4_q, acc5_q;
  logic [15:0]     r1_q, r2_q;

  // One Horner step: floor(acc * r / 2^13) + c.
  function automatic rpae_pkg::acc_t horner(input rpae_pkg::acc_t acc,
                                            input logic [15:0] r,
                                            input rpae_pkg::coef_t c);
    logic signed [rpae_pkg::AccW+16:0] p;
    p = acc * $signed({1'b0, r});
    return rpae_pkg::AccW'(p >>> rpae_pkg::RadFrac) + rpae_pkg::AccW'(c);
  endfunction

  // Inactive terms read as zero, so Horner can always run all steps.
  assign n_eff = (terms_i > 3'(rpae_pkg::MaxTerms)) ? 3'(rpae_pkg::MaxTerms) : terms_i;

  always_comb begin
    for (int i = 0; i < rpae_pkg::NumCoef; i++) begin
      ceff[i] = (3'(i) < n_eff) ? coef_i[i] : '0;
    end
  end

  assign acc1_d = horner(rpae_pkg::AccW'(ceff[3]), radius_i, ceff[2]);
  assign acc2_d = horner(acc1_q, r1_q, ceff[1]);
  assign acc3_d = horner(acc2_q, r2_q, ceff[0]);

  // Three Horner stages, then two delay stages to line up with the angle path.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc1_q <= acc1_d;
      r1_q   <= radius_i;
      acc2_q <= acc2_d;
      r2_q   <= r1_q;
      acc3_q <= acc3_d;
      acc4_q <= acc3_q;
      acc5_q <= acc4_q;
    end
  end

  assign acc_o = acc5_q;

endmodule

FILE: design/rpae_angular.sv
module rpae_angular (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [15:0]    angle_i,
  input  logic [6:0]     freq_i,
  output rpae_pkg::af_t  af_o
);

  logic [15:0] mext;
  logic [15:0] phase;
  logic [14:0] x_d;
  logic [28:0] sq;
  logic [24:0] cz;
  logic [27:0] tz;
  logic [28:0] ux;
  logic [14:0] s;

  logic [14:0] x1_q, x2_q, x3_q, x4_q;
  logic        neg1_q, neg2_q, neg3_q, neg4_q;
  logic [14:0] z2_q, z3_q;
  logic [13:0] t1_q;
  logic [14:0] u_q;
  rpae_pkg::af_t af_q;

  // Phase = m*angle mod one turn, shifted a quarter turn for cosine if m >= 0.
  always_comb begin
    mext  = {{9{freq_i[6]}}, freq_i};
    phase = 16'(angle_i * mext);
    if (!freq_i[6]) begin
      phase = phase + 16'h4000;
    end
    x_d = phase[14] ? (rpae_pkg::AngOne - {1'b0, phase[13:0]}) : {1'b0, phase[13:0]};
  end

  assign sq = x1_q * x1_q;
  assign cz = rpae_pkg::SinC * z2_q;
  assign tz = t1_q * z3_q;
  assign ux = u_q * x4_q;
  assign s  = ux[28:14];

  // Five stages: fold, square, and three steps of the odd polynomial.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q   <= x_d;
      neg1_q <= phase[15];
      z2_q   <= sq[28:14];
      x2_q   <= x1_q;
      neg2_q <= neg1_q;
      t1_q   <= rpae_pkg::SinB - 14'(cz[24:14]);
      z3_q   <= z2_q;
      x3_q   <= x2_q;
      neg3_q <= neg2_q;
      u_q    <= rpae_pkg::SinA - {1'b0, tz[27:14]};
      x4_q   <= x3_q;
      neg4_q <= neg3_q;
      af_q   <= neg4_q ? -$signed({1'b0, s}) : $signed({1'b0, s});
    end
  end

  assign af_o = af_q;

endmodule

FILE: tb/radial_poly_azimuthal_eval_tb.sv
module radial_poly_azimuthal_eval_tb;

  // Register indexes that the block does not decode.
  localparam rpae_pkg::cfg_idx_t CfgSpare6 = 3'd6;
  localparam rpae_pkg::cfg_idx_t CfgSpare7 = 3'd7;
  localparam int unsigned SettleCycles = 12;

  typedef struct packed {
    logic signed [31:0] value;
    logic               saturated;
  } eval_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [15:0] radius_i = '0;
  logic [15:0] angle_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic signed [31:0] value_o;
  logic        saturated_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  // Shadow copy of the configuration registers.
  rpae_pkg::coef_t    coef_shadow [rpae_pkg::NumCoef];
  logic [2:0]         terms_shadow;
  logic signed [6:0]  freq_shadow;

  eval_result_t pending_products[$];
  int unsigned  mismatch_count = 0;
  int unsigned  hold_off_cycles = 0;
  bit           stalls_enabled = 1'b1;

  radial_poly_azimuthal_eval u_top (.*);

  // Clock generation.
  always #5 clk_i = ~clk_i;

  // Radial polynomial by Horner's rule times the angular factor, saturated.
  function automatic eval_result_t eval_product(logic [15:0] rad, logic [15:0] ang);
    eval_result_t res;
    longint       acc;
    longint       prod;
    int           n;
    int unsigned  ph, q, x, z2, t;
    int           af;
    n = (terms_shadow > rpae_pkg::MaxTerms) ? rpae_pkg::MaxTerms : terms_shadow;
    acc = 0;
    if (n > 0) begin
      acc = longint'(coef_shadow[n-1]);
      for (int i = n - 2; i >= 0; i--) begin
        acc = ((acc * longint'(rad)) >>> rpae_pkg::RadFrac) + longint'(coef_shadow[i]);
      end
    end
    ph = (int'(freq_shadow) * int'(ang)) & 32'hFFFF;
    if (freq_shadow >= 0) begin
      ph = (ph + int'(rpae_pkg::AngOne)) & 32'hFFFF;
    end
    q = (ph >> 14) & 3;
    x = ph & 32'h3FFF;
    if (q[0]) begin
      x = int'(rpae_pkg::AngOne) - x;
    end
    z2 = (x * x) >> 14;
    t = (int'(rpae_pkg::SinC) * z2) >> 14;
    t = int'(rpae_pkg::SinB) - t;
    t = (t * z2) >> 14;
    t = int'(rpae_pkg::SinA) - t;
    t = (t * x) >> 14;
    af = (q >= 2) ? -int'(t) : int'(t);
    prod = (acc * longint'(af)) >>> rpae_pkg::AngFrac;
    res.saturated = 1'b1;
    if (prod > 64'sd2147483647) begin
      res.value = 32'h7FFF_FFFF;
    end else if (prod < -64'sd2147483648) begin
      res.value = 32'h8000_0000;
    end else begin
      res.value = prod[31:0];
      res.saturated = 1'b0;
    end
    return res;
  endfunction

  function automatic int unsigned rand_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (!stalls_enabled || roll < 60) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 5);
  endfunction

  // Receiver: random stalls, plus a counted long hold-off on request.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_cycles > 0) begin
        out_ready_i = 1'b0;
        hold_off_cycles--;
      end else if (stall_left > 0) begin
        out_ready_i = 1'b0;
        stall_left--;
      end else begin
        out_ready_i = 1'b1;
        if (stalls_enabled) stall_left = rand_gap();
      end
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    eval_result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_products.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("Unexpected result: value %0d saturated %0b", value_o, saturated_o);
        end
      end else begin
        exp_res = pending_products.pop_front();
        if (value_o !== exp_res.value || saturated_o !== exp_res.saturated) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("Mismatch: expected value %0d sat %0b, got value %0d sat %0b",
                     exp_res.value, exp_res.saturated, value_o, saturated_o);
          end
        end
      end
    end
  end

  // Send one request and record its expected result on acceptance.
  task automatic send_item(logic [15:0] rad, logic [15:0] ang, int unsigned gap);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    radius_i   = rad;
    angle_i    = ang;
    do @(posedge clk_i); while (!in_ready_o);
    pending_products.push_back(eval_product(rad, ang));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_products.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Register write; only issued with the pipeline empty.
  task automatic write_reg(rpae_pkg::cfg_idx_t idx, logic [31:0] data);
    wait_drained();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      rpae_pkg::CfgCoef0, rpae_pkg::CfgCoef1, rpae_pkg::CfgCoef2, rpae_pkg::CfgCoef3:
        coef_shadow[idx[1:0]] = data;
      rpae_pkg::CfgTerms: terms_shadow = data[2:0];
      rpae_pkg::CfgFreq:  freq_shadow = data[6:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic load_config(logic [31:0] c0, logic [31:0] c1, logic [31:0] c2,
                             logic [31:0] c3, logic [2:0] terms, logic [6:0] freq);
    write_reg(rpae_pkg::CfgCoef0, c0);
    write_reg(rpae_pkg::CfgCoef1, c1);
    write_reg(rpae_pkg::CfgCoef2, c2);
    write_reg(rpae_pkg::CfgCoef3, c3);
    write_reg(rpae_pkg::CfgTerms, {29'd0, terms});
    write_reg(rpae_pkg::CfgFreq, {25'd0, freq});
  endtask

  // Reset defaults: all coefficients zero, so every value is zero.
  task automatic test_reset_defaults();
    send_item(16'hFFFF, 16'h0000, 0);
    send_item(16'h0000, 16'hFFFF, 0);
  endtask

  // Field extremes, every term count, cosine and sine paths, wrap and saturation.
  task automatic test_directed();
    load_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                3'd4, 7'd0);
    send_item(16'hFFFF, 16'h1234, 0);  // positive saturation
    send_item(16'h0000, 16'h0000, 0);
    send_item(16'h2000, 16'hFFFF, 0);
    load_config(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                3'd7, 7'h40);          // too many terms, most negative m
    send_item(16'hFFFF, 16'h4000, 0);
    send_item(16'hFFFF, 16'h0001, 0);
    send_item(16'h8000, 16'hC000, 0);
    write_reg(rpae_pkg::CfgTerms, 32'd0);        // no terms
    send_item(16'hFFFF, 16'h8000, 0);
    write_reg(rpae_pkg::CfgTerms, 32'd1);
    write_reg(rpae_pkg::CfgFreq, 32'h7F);        // m = -1, sine path
    send_item(16'h1000, 16'h4000, 0);
    send_item(16'h1000, 16'hC000, 0);
    write_reg(rpae_pkg::CfgTerms, 32'd2);
    write_reg(rpae_pkg::CfgFreq, 32'd1);
    send_item(16'h2000, 16'h8000, 0);
    send_item(16'h2000, 16'h2000, 0);
    write_reg(rpae_pkg::CfgTerms, 32'd3);
    write_reg(rpae_pkg::CfgFreq, 32'd32);
    send_item(16'hFFFF, 16'h0800, 0);
    write_reg(rpae_pkg::CfgFreq, 32'h3F);        // m beyond +32, phase wraps
    send_item(16'h5555, 16'hAAAA, 0);
    write_reg(rpae_pkg::CfgFreq, 32'h60);        // m = -32
    send_item(16'hAAAA, 16'h5555, 0);
  endtask

  // Writes to undecoded indexes must leave the configuration untouched.
  task automatic test_spare_index();
    write_reg(CfgSpare6, 32'hFFFF_FFFF);
    write_reg(CfgSpare7, 32'h0000_0003);
    send_item(16'h3000, 16'h1111, 0);
    send_item(16'hF000, 16'hEEEE, 0);
  endtask

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom();
      default: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
    endcase
  endfunction

  function automatic logic [15:0] rand_radius();
    if ($urandom_range(3) == 0) return 16'($urandom_range(16'hFFFF, 16'hF000));
    return 16'($urandom());
  endfunction

  // Random configurations, each followed by a batch of random requests.
  task automatic test_random(int unsigned total);
    int unsigned sent;
    int unsigned batch;
    sent = 0;
    while (sent < total) begin
      load_config(rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                  3'($urandom_range(7)), 7'($urandom_range(127)));
      stalls_enabled = ($urandom_range(4) != 0);
      batch = $urandom_range(120, 60);
      if (batch > total - sent) batch = total - sent;
      repeat (batch) begin
        send_item(rand_radius(), 16'($urandom()), rand_gap());
      end
      sent += batch;
    end
    stalls_enabled = 1'b1;
  endtask

  // Receiver holds off long enough for the pipeline to fill and stall input.
  task automatic test_backpressure();
    load_config(32'h0001_0000, 32'h0000_8000, 32'hFFFF_0000, 32'h0000_4000,
                3'd4, 7'd3);
    @(negedge clk_i);
    hold_off_cycles = 200;
    repeat (40) send_item(16'($urandom()), 16'($urandom()), 0);
  endtask

  // Sender pauses until all outstanding results are back, then resumes.
  task automatic test_sender_pause();
    repeat (20) send_item(16'($urandom()), 16'($urandom()), rand_gap());
    wait_drained();
    repeat (20) send_item(16'($urandom()), 16'($urandom()), 0);
  endtask

  initial begin
    coef_shadow  = '{default: '0};
    terms_shadow = 3'd4;
    freq_shadow  = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_defaults();
    test_directed();
    test_spare_index();
    test_backpressure();
    test_sender_pause();
    test_random(1300);
    wait_drained();
    if (mismatch_count == 0 && pending_products.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: radial_poly_azimuthal_eval.f
design/rpae_pkg.sv
design/rpae_radial.sv
design/rpae_angular.sv
design/radial_poly_azimuthal_eval.sv
tb/radial_poly_azimuthal_eval_tb.sv
